>>> src/sarfp_pkg.sv
// Shared types and constants for the sonar ASCII range frame parser.
package sarfp_pkg;

  localparam int DIST_W = 10;
  localparam int AGE_W  = 8;
  localparam int BYTE_W = 8;
  localparam int IDX_W  = 2;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h52;
  localparam logic [BYTE_W-1:0] CHAR_0    = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9    = 8'h39;

  localparam logic [DIST_W-1:0] ACC_MAX = 10'd1023;
  localparam logic [AGE_W-1:0]  AGE_MAX = 8'd255;

  localparam logic CMD_BYTE   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [IDX_W-1:0] REG_MIN_DISTANCE = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_DISTANCE = 2'd1;
  localparam logic [IDX_W-1:0] REG_STALE_LIMIT  = 2'd2;

  localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 10'd0;
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RESET = 10'd999;
  localparam logic [AGE_W-1:0]  STALE_LIMIT_RESET  = 8'd5;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance_cm;
    logic              healthy;
  } out_item_t;

  // A finished frame, handed from the byte parser to the sample logic.
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] value;
  } commit_t;

endpackage

>>> src/sarfp_frame_parser.sv
// Byte-level frame parser: sync on 'R', accumulate decimal digits, commit on terminator.
module sarfp_frame_parser import sarfp_pkg::*; #(
  parameter int DIGIT_COUNT = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic [BYTE_W-1:0] rx_byte,
  output commit_t           commit
);

  localparam int POS_W = $clog2(DIGIT_COUNT + 2);
  localparam logic [POS_W-1:0] POS_IDLE = '0;
  localparam logic [POS_W-1:0] POS_LAST_DIGIT = POS_W'(DIGIT_COUNT);
  localparam logic [POS_W-1:0] POS_TERM = POS_W'(DIGIT_COUNT + 1);

  logic [POS_W-1:0]  frame_position;
  logic [DIST_W-1:0] digit_accumulator;
  logic              digits_stopped;

  logic [POS_W-1:0]  frame_position_next;
  logic [DIST_W-1:0] digit_accumulator_next;
  logic              digits_stopped_next;

  logic              is_digit;
  logic [3:0]        digit_value;
  logic [DIST_W+3:0] acc_times_ten;
  logic [DIST_W+3:0] acc_sum;

  assign is_digit    = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
  assign digit_value = 4'(rx_byte - CHAR_0);
  // Multiply by ten as two shifts and an add.
  assign acc_times_ten = ({4'd0, digit_accumulator} << 3) + ({4'd0, digit_accumulator} << 1);
  assign acc_sum       = acc_times_ten + {{DIST_W{1'b0}}, digit_value};

  assign commit.valid = byte_valid && (frame_position == POS_TERM);
  assign commit.value = digit_accumulator;

  always_comb begin
    frame_position_next    = frame_position;
    digit_accumulator_next = digit_accumulator;
    digits_stopped_next    = digits_stopped;
    if (byte_valid) begin
      if (frame_position == POS_IDLE) begin
        if (rx_byte == SYNC_BYTE) begin
          frame_position_next    = POS_W'(1);
          digit_accumulator_next = '0;
          digits_stopped_next    = 1'b0;
        end
      end else if (frame_position <= POS_LAST_DIGIT) begin
        if (!digits_stopped && is_digit) begin
          if (acc_sum > {4'd0, ACC_MAX}) begin
            digit_accumulator_next = ACC_MAX;
          end else begin
            digit_accumulator_next = acc_sum[DIST_W-1:0];
          end
        end else begin
          digits_stopped_next = 1'b1;
        end
        frame_position_next = frame_position + POS_W'(1);
      end else begin
        frame_position_next    = POS_IDLE;
        digit_accumulator_next = '0;
        digits_stopped_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position    <= POS_IDLE;
      digit_accumulator <= '0;
      digits_stopped    <= 1'b0;
    end else begin
      frame_position    <= frame_position_next;
      digit_accumulator <= digit_accumulator_next;
      digits_stopped    <= digits_stopped_next;
    end
  end

endmodule

>>> src/sonar_ascii_range_frame_parser_unit.sv
// Top level of the sonar ASCII range frame parser.
// Each input word is either one received serial byte (cmd 0) or a sample request (cmd 1);
// a word is taken every cycle that in_stall is low, and only sample requests produce an
// output word, which is registered. Frames are 'R', DIGIT_COUNT ASCII digits and any
// terminator byte; digits accumulate until the first non-digit and the terminator commits the
// value as the latest distance and clears the age. A sample returns the latest distance clamped
// to [min_distance_cm, max_distance_cm] and a healthy flag that requires the raw distance to be
// within the limits and the age (samples since the last frame, saturating at 255) to be no more
// than stale_limit. A result register plus one skid register let the block keep taking words
// while a result waits; in_stall rises only when both are occupied. Configuration registers
// (index 0 min, 1 max, 2 stale limit) are always ready and should be written while idle.
module sonar_ascii_range_frame_parser_unit import sarfp_pkg::*; #(
  parameter int DIGIT_COUNT = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DIST_W-1:0] cfg_data
);

  logic [DIST_W-1:0] min_distance_cm;
  logic [DIST_W-1:0] max_distance_cm;
  logic [AGE_W-1:0]  stale_limit;
  logic [DIST_W-1:0] last_distance;
  logic [AGE_W-1:0]  sample_age;

  logic      skid_valid;
  out_item_t skid_data;

  logic      in_accept;
  logic      byte_accept;
  logic      sample_accept;
  logic      out_free;
  commit_t   commit;
  out_item_t result;
  logic      below_min;
  logic      above_max;

  assign cfg_ready     = 1'b1;
  assign in_stall      = skid_valid;
  assign in_accept     = in_valid && !in_stall;
  assign byte_accept   = in_accept && (in_data.cmd == CMD_BYTE);
  assign sample_accept = in_accept && (in_data.cmd == CMD_SAMPLE);
  assign out_free      = !out_valid || !out_stall;

  sarfp_frame_parser #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_accept),
    .rx_byte    (in_data.rx_byte),
    .commit     (commit)
  );

  assign below_min = last_distance < min_distance_cm;
  assign above_max = last_distance > max_distance_cm;

  always_comb begin
    if (below_min) begin
      result.distance_cm = min_distance_cm;
    end else if (above_max) begin
      result.distance_cm = max_distance_cm;
    end else begin
      result.distance_cm = last_distance;
    end
    result.healthy = !below_min && !above_max && (sample_age <= stale_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance_cm <= MIN_DISTANCE_RESET;
      max_distance_cm <= MAX_DISTANCE_RESET;
      stale_limit     <= STALE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MIN_DISTANCE: min_distance_cm <= cfg_data;
        REG_MAX_DISTANCE: max_distance_cm <= cfg_data;
        REG_STALE_LIMIT:  stale_limit     <= cfg_data[AGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_distance <= '0;
      sample_age    <= AGE_MAX;
    end else if (commit.valid) begin
      last_distance <= commit.value;
      sample_age    <= '0;
    end else if (sample_accept && (sample_age != AGE_MAX)) begin
      sample_age <= sample_age + AGE_W'(1);
    end
  end

  // Output register with one skid entry; the skid fills only when the output is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= sample_accept;
      end
    end else if (sample_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (sample_accept) begin
        out_data <= result;
      end
    end else if (sample_accept) begin
      skid_data <= result;
    end
  end

endmodule

>>> src/sarfp_checker.sv
// Port-level checks for the range frame parser, bound to the top level.
module sarfp_checker import sarfp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Reset empties the output side.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word present after reset");

  // A received byte never produces an output word.
  a_byte_no_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.cmd == CMD_BYTE && !out_valid) |=> !out_valid)
    else $error("output word appeared for a received byte");

  // A sample request taken into an empty output shows up in the next cycle.
  a_sample_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.cmd == CMD_SAMPLE && !out_valid) |=> out_valid)
    else $error("sample request produced no output word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed");

endmodule

bind sonar_ascii_range_frame_parser_unit sarfp_checker u_sarfp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> sim/tb_sarfp_model_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the range samples of the frame parser.
package tb_sarfp_model_pkg;
  import sarfp_pkg::*;

  localparam int FRAME_DIGITS = 3;

  class range_sample_ledger;
    logic [DIST_W-1:0] min_cm;
    logic [DIST_W-1:0] max_cm;
    logic [AGE_W-1:0]  stale_lim;
    logic [DIST_W-1:0] acc_cm;
    logic [DIST_W-1:0] last_cm;
    logic [AGE_W-1:0]  age;
    int                slot;
    bit                stopped;
    int unsigned       errors;
    out_item_t         expected_samples[$];

    function void reset_model();
      min_cm    = MIN_DISTANCE_RESET;
      max_cm    = MAX_DISTANCE_RESET;
      stale_lim = STALE_LIMIT_RESET;
      acc_cm    = '0;
      last_cm   = '0;
      age       = AGE_MAX;
      slot      = 0;
      stopped   = 1'b0;
      errors    = 0;
      expected_samples.delete();
    endfunction

    function void write_limit(logic [IDX_W-1:0] idx, logic [DIST_W-1:0] data);
      case (idx)
        REG_MIN_DISTANCE: min_cm = data;
        REG_MAX_DISTANCE: max_cm = data;
        REG_STALE_LIMIT:  stale_lim = data[AGE_W-1:0];
        default: ;
      endcase
    endfunction

    // Bytes only move the frame parser; a sample request yields one word and ages the reading.
    function void note_word(in_item_t w);
      int unsigned next_acc;
      out_item_t   want;
      if (w.cmd == CMD_BYTE) begin
        if (slot == 0) begin
          if (w.rx_byte == SYNC_BYTE) begin
            slot    = 1;
            acc_cm  = '0;
            stopped = 1'b0;
          end
        end else if (slot <= FRAME_DIGITS) begin
          if (!stopped && w.rx_byte >= CHAR_0 && w.rx_byte <= CHAR_9) begin
            next_acc = acc_cm * 10 + (w.rx_byte - CHAR_0);
            acc_cm = (next_acc > ACC_MAX) ? ACC_MAX : next_acc[DIST_W-1:0];
          end else begin
            stopped = 1'b1;
          end
          slot++;
        end else begin
          // Whatever byte sits in the terminator slot commits the frame.
          last_cm = acc_cm;
          age     = '0;
          slot    = 0;
          acc_cm  = '0;
          stopped = 1'b0;
        end
      end else begin
        if (last_cm < min_cm) begin
          want.distance_cm = min_cm;
        end else if (last_cm > max_cm) begin
          want.distance_cm = max_cm;
        end else begin
          want.distance_cm = last_cm;
        end
        want.healthy = (last_cm >= min_cm) && (last_cm <= max_cm) && (age <= stale_lim);
        expected_samples.push_back(want);
        if (age != AGE_MAX) age++;
      end
    endfunction

    function void check_sample(out_item_t got);
      out_item_t want;
      if (expected_samples.size() == 0) begin
        $error("unexpected sample word: distance_cm %0d healthy %0b", got.distance_cm,
               got.healthy);
        errors++;
        return;
      end
      want = expected_samples[0];
      expected_samples.delete(0);
      if (got.distance_cm !== want.distance_cm) begin
        $error("distance_cm: expected %0d, actual %0d", want.distance_cm, got.distance_cm);
        errors++;
      end
      if (got.healthy !== want.healthy) begin
        $error("healthy: expected %0b, actual %0b", want.healthy, got.healthy);
        errors++;
      end
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction
  endclass

endpackage

>>> sim/tb_sonar_ascii_range_frame_parser_unit.sv
`timescale 1ns / 1ps
// Testbench top that drives the range frame parser with frames, noise and sample requests.
module tb_sonar_ascii_range_frame_parser_unit;
  import sarfp_pkg::*;
  import tb_sarfp_model_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_pattern_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [DIST_W-1:0] cfg_data;

  range_sample_ledger ledger;
  int unsigned        cycle_count = 0;
  int unsigned        hold_requests = 0;
  int unsigned        hold_served = 0;
  int unsigned        hold_left = 0;
  int unsigned        pattern_left = 0;
  stall_pattern_t     pattern = STALL_NONE;
  int unsigned        burst_left = 0;
  bit                 steady_sender = 1'b0;

  sonar_ascii_range_frame_parser_unit #(.DIGIT_COUNT(FRAME_DIGITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Results are checked before the same edge's input is noted, so a word can never
  // be matched against an expectation created at the edge it arrives on.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) ledger.check_sample(out_data);
      if (in_valid && in_stall === 1'b0) ledger.note_word(in_data);
      if (cfg_valid && cfg_ready === 1'b1) ledger.write_limit(cfg_index, cfg_data);
    end
  end

  // Receiver: switches among stall patterns and serves long hold-off requests.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (pattern_left == 0) begin
      pattern      = stall_pattern_t'($urandom_range(0, 3));
      pattern_left = $urandom_range(20, 120);
    end else begin
      pattern_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (pattern)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
        STALL_PERIODIC: out_stall <= (pattern_left % 3 == 0);
        default:        out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  task automatic offer_word(input in_item_t w);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // The sender works in bursts; between bursts it idles for a random number of cycles.
  task automatic send_word(input in_item_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        go_quiet();
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    offer_word(w);
    burst_left--;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    in_item_t w;
    w.cmd     = CMD_BYTE;
    w.rx_byte = b;
    send_word(w);
  endtask

  task automatic send_sample();
    in_item_t w;
    w.cmd     = CMD_SAMPLE;
    w.rx_byte = 8'($urandom_range(0, 255));
    send_word(w);
  endtask

  task automatic send_frame(input logic [BYTE_W-1:0] d0, d1, d2, term);
    send_byte(SYNC_BYTE);
    send_byte(d0);
    send_byte(d1);
    send_byte(d2);
    send_byte(term);
  endtask

  task automatic send_random_frame();
    send_byte(SYNC_BYTE);
    for (int i = 0; i < FRAME_DIGITS; i++) begin
      if ($urandom_range(0, 9) < 8) send_byte(CHAR_0 + 8'($urandom_range(0, 9)));
      else send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0) send_sample();
    end
    send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic sample_run(input int unsigned count);
    repeat (count) send_sample();
  endtask

  task automatic wait_drained();
    go_quiet();
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIST_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Bytes produce no word, so wait on past the last result before writing.
  task automatic set_limits(input logic [DIST_W-1:0] lo, hi, input logic [AGE_W-1:0] stale);
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_MIN_DISTANCE, lo);
    write_reg(REG_MAX_DISTANCE, hi);
    write_reg(REG_STALE_LIMIT, {2'b00, stale});
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    int unsigned k;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_random_frame();
        done += FRAME_DIGITS + 2;
      end else if (pick < 88) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
        sample_run(k);
        done += k;
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        done += 1;
      end
    end
  endtask

  // The receiver holds off while samples keep coming, so the block fills and stalls its input.
  task automatic squeeze_output();
    steady_sender = 1'b1;
    hold_requests++;
    sample_run(40);
    steady_sender = 1'b0;
    wait_drained();
  endtask

  initial begin
    ledger = new();
    ledger.reset_model();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MIN_DISTANCE;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed words under the reset limits.
    send_sample();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame("9", "9", "9", 8'h0A);
    send_sample();
    send_frame("0", "0", "0", 8'h0D);
    send_sample();
    send_frame("7", "R", "5", "R");
    send_sample();
    send_frame(" ", "1", "2", "-");
    send_sample();

    set_limits(10'd100, 10'd500, 8'd3);
    run_random(80);

    set_limits(10'd0, 10'd0, 8'd0);
    run_random(30);
    squeeze_output();
    run_random(50);

    // Age the reading until it saturates, then check that a limit of 255 still counts it fresh.
    set_limits(10'd999, 10'd999, 8'd254);
    send_random_frame();
    sample_run(258);
    set_limits(10'd0, 10'd1023, 8'd255);
    sample_run(4);

    set_limits(10'd1010, 10'd1023, 8'd255);
    run_random(50);

    set_limits(10'd600, 10'd200, 8'd10);
    run_random(70);

    steady_sender = 1'b1;
    set_limits(10'd0, 10'd999, 8'd255);
    run_random(70);
    steady_sender = 1'b0;

    set_limits(10'($urandom_range(0, 999)), 10'($urandom_range(0, 999)),
               8'($urandom_range(0, 20)));
    run_random(70);

    set_limits(10'd0, 10'd1023, 8'd1);
    run_random(70);

    wait_drained();
    repeat (8) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
